/* rtl/ibfs_pkg.sv */
// ============================================================================
// ibfs_pkg
// Shared constants, codes and helper functions of the inode file store core.
// ============================================================================
`default_nettype none

package ibfs_pkg;

	// Geometry of the store.
	localparam int BLOCK_BYTES      = 512;
	localparam int DATA_BLOCK_COUNT = 256;
	localparam int FILE_COUNT       = 64;
	localparam int DIRECT_PER_FILE  = 12;
	localparam int HANDLE_COUNT     = 16;

	localparam int SCAN_W      = 16;
	localparam int SCAN_IDX_W  = $clog2(SCAN_W);
	localparam int BLK_W       = $clog2(DATA_BLOCK_COUNT);
	localparam int FILE_W      = $clog2(FILE_COUNT);
	localparam int HDL_W       = $clog2(HANDLE_COUNT);
	localparam int INBLK_W     = $clog2(BLOCK_BYTES);
	localparam int OFF_W       = 13;
	localparam int ENTRY_W     = BLK_W + 1;
	localparam int TBL_DEPTH   = FILE_COUNT * DIRECT_PER_FILE;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);
	localparam int BYTE_DEPTH  = DATA_BLOCK_COUNT * BLOCK_BYTES;
	localparam int BYTE_AW     = $clog2(BYTE_DEPTH);
	localparam int DIR_IDX_W   = $clog2(DIRECT_PER_FILE);
	localparam int BI_W        = OFF_W - INBLK_W;
	localparam int FCNT_W      = 9;
	localparam int FFCNT_W     = 6;
	localparam int CHUNK_W     = BLK_W - SCAN_IDX_W;
	localparam int FCHUNK_W    = FILE_W - SCAN_IDX_W;

	// Stream widths.
	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 3;

	// Operation codes.
	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_OPEN   = 3'd1;
	localparam logic [2:0] OP_CLOSE  = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;
	localparam logic [2:0] OP_DELETE = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd1;
	localparam logic [2:0] ST_EOF        = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
	localparam logic [2:0] ST_NO_SPACE   = 3'd4;
	localparam logic [2:0] ST_NO_FILE    = 3'd5;
	localparam logic [2:0] ST_NO_HANDLE  = 3'd6;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd7;

	// Result of a lowest-set-bit search over one scan chunk.
	typedef struct packed {
		logic                  found;
		logic [SCAN_IDX_W-1:0] idx;
	} scan_t;

	// Finds the lowest set bit of a chunk.
	function automatic scan_t lowest_set(input logic [SCAN_W-1:0] bits);
		scan_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (bits[i]) begin
				r.found = 1'b1;
				r.idx   = SCAN_IDX_W'(i);
			end
		end
		return r;
	endfunction

	// Address of a block table slot: file * DIRECT_PER_FILE + index.
	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [FILE_W-1:0] f,
			input logic [BI_W-1:0] bi);
		return TBL_AW'(f * DIRECT_PER_FILE) + TBL_AW'(bi);
	endfunction

endpackage

`default_nettype wire

/* rtl/inode_block_file_store_core.sv */
// ============================================================================
// inode_block_file_store_core
// File store with direct block tables, bitmap allocation and open handles.
// ============================================================================
// Each input transfer carries one operation and yields exactly one result
// transfer. The block works on one operation at a time; a finished result
// waits in the output register while the next operation is taken. A write
// that must allocate a block scans the free-block bitmap 16 blocks per
// cycle. Create scans for a free file number and then clears the new
// file's 12 block table slots one at a time through the single write port
// of the table memory. Delete reads back each of the file's 12 table slots
// from the table memory before it frees that slot's block. File lengths,
// block tables and data bytes live in synchronous memories with registered
// read data.
// ============================================================================
`default_nettype none

module inode_block_file_store_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// handle [3:0], file_id [9:4], data_in [17:10], zero fill above
	input  wire logic [ibfs_pkg::S_DATA_W-1:0] s_tdata,
	// op [2:0]
	input  wire logic [ibfs_pkg::S_USER_W-1:0] s_tuser,
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// data_out [7:0], handle_out [11:8], file_id_out [17:12],
	// spare_blocks [26:18], free_files [32:27], zero fill above
	output logic [ibfs_pkg::M_DATA_W-1:0]      m_tdata,
	// status [2:0]
	output logic [ibfs_pkg::M_USER_W-1:0]      m_tuser,
	output logic                               m_tlast
);
	import ibfs_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISPATCH  = 4'd1;
	localparam logic [3:0] S_RW_CHK    = 4'd2;
	localparam logic [3:0] S_BLK_SCAN  = 4'd3;
	localparam logic [3:0] S_BYTE_RD   = 4'd4;
	localparam logic [3:0] S_FILE_SCAN = 4'd5;
	localparam logic [3:0] S_TBL_CLR   = 4'd6;
	localparam logic [3:0] S_DEL_RD    = 4'd7;
	localparam logic [3:0] S_DEL_CHK   = 4'd8;
	localparam logic [3:0] S_DONE      = 4'd9;

	// Control state.
	logic [3:0]                  state_q, state_d;
	logic [DATA_BLOCK_COUNT-1:0] block_used_q, block_used_d;
	logic [FILE_COUNT-1:0]       file_used_q, file_used_d;
	logic [HANDLE_COUNT-1:0]     handle_valid_q, handle_valid_d;
	logic [FCNT_W-1:0]           free_blk_cnt_q, free_blk_cnt_d;
	logic [FFCNT_W-1:0]          free_file_cnt_q, free_file_cnt_d;
	logic                        m_tvalid_q, m_tvalid_d;

	// Payload state.
	logic [FILE_W-1:0]  handle_file_q [HANDLE_COUNT];
	logic [FILE_W-1:0]  handle_file_d [HANDLE_COUNT];
	logic [OFF_W-1:0]   handle_off_q [HANDLE_COUNT];
	logic [OFF_W-1:0]   handle_off_d [HANDLE_COUNT];
	logic [2:0]         op_q, op_d;
	logic [HDL_W-1:0]   hdl_q, hdl_d;
	logic [FILE_W-1:0]  fid_q, fid_d;
	logic [7:0]         din_q, din_d;
	logic               fin_q, fin_d;
	logic [OFF_W-1:0]   off_q, off_d;
	logic [TBL_AW-1:0]  slot_q, slot_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic [BI_W-1:0]    idx_q, idx_d;
	logic [2:0]         res_st_q, res_st_d;
	logic [7:0]         res_dout_q, res_dout_d;
	logic [HDL_W-1:0]   res_hout_q, res_hout_d;
	logic [FILE_W-1:0]  res_fout_q, res_fout_d;
	logic [M_DATA_W-1:0] m_data_q, m_data_d;
	logic [2:0]          m_user_q, m_user_d;
	logic                m_last_q, m_last_d;

	// Memories and their ports.
	logic [OFF_W-1:0]   len_mem [FILE_COUNT];
	logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
	logic [7:0]         byte_mem [BYTE_DEPTH];

	logic               len_we, len_re;
	logic [FILE_W-1:0]  len_wa, len_ra;
	logic [OFF_W-1:0]   len_wd, len_rd_q;
	logic               tbl_we, tbl_re;
	logic [TBL_AW-1:0]  tbl_wa, tbl_ra;
	logic [ENTRY_W-1:0] tbl_wd, tbl_rd_q;
	logic               byte_we, byte_re;
	logic [BYTE_AW-1:0] byte_wa, byte_ra;
	logic [7:0]         byte_wd, byte_rd_q;

	// Helper views.
	logic [FILE_W-1:0]  h_file;
	logic [OFF_W-1:0]   h_off;
	logic               h_ok;
	logic [BI_W-1:0]    h_bi;
	logic               e_ok;
	logic [BLK_W-1:0]   e_blk;
	logic [OFF_W-1:0]   off_inc;
	logic [SCAN_W-1:0]  file_free_bits;
	scan_t              hdl_scan, blk_scan, file_scan;
	logic [BLK_W-1:0]   new_blk;
	logic [FILE_W-1:0]  new_file;
	logic               fid_live;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// Lookups on the current handle, table entry and bitmaps.
	always_comb begin
		h_file   = handle_file_q[hdl_q];
		h_off    = handle_off_q[hdl_q];
		h_ok     = handle_valid_q[hdl_q] && file_used_q[h_file];
		h_bi     = h_off[OFF_W-1:INBLK_W];
		e_ok     = (tbl_rd_q != '0) && (tbl_rd_q <= ENTRY_W'(DATA_BLOCK_COUNT));
		e_blk    = BLK_W'(tbl_rd_q - ENTRY_W'(1));
		off_inc  = off_q + OFF_W'(1);
		fid_live = (fid_q != '0) && file_used_q[fid_q];
		hdl_scan = lowest_set(~handle_valid_q);
		blk_scan = lowest_set(~block_used_q[{chunk_q, SCAN_IDX_W'(0)} +: SCAN_W]);
		file_free_bits = ~file_used_q[{chunk_q[FCHUNK_W-1:0], SCAN_IDX_W'(0)} +: SCAN_W];
		if (chunk_q[FCHUNK_W-1:0] == '0) begin
			file_free_bits[0] = 1'b0;
		end
		file_scan = lowest_set(file_free_bits);
		new_blk   = {chunk_q, blk_scan.idx};
		new_file  = {chunk_q[FCHUNK_W-1:0], file_scan.idx};
	end

	// Operation sequencer.
	always_comb begin
		state_d         = state_q;
		block_used_d    = block_used_q;
		file_used_d     = file_used_q;
		handle_valid_d  = handle_valid_q;
		free_blk_cnt_d  = free_blk_cnt_q;
		free_file_cnt_d = free_file_cnt_q;
		handle_file_d   = handle_file_q;
		handle_off_d    = handle_off_q;
		op_d            = op_q;
		hdl_d           = hdl_q;
		fid_d           = fid_q;
		din_d           = din_q;
		fin_d           = fin_q;
		off_d           = off_q;
		slot_d          = slot_q;
		chunk_d         = chunk_q;
		idx_d           = idx_q;
		res_st_d        = res_st_q;
		res_dout_d      = res_dout_q;
		res_hout_d      = res_hout_q;
		res_fout_d      = res_fout_q;
		m_data_d        = m_data_q;
		m_user_d        = m_user_q;
		m_last_d        = m_last_q;
		m_tvalid_d      = m_tvalid_q && !m_tready;
		len_we  = 1'b0; len_wa  = fid_q; len_wd = '0;
		len_re  = 1'b0; len_ra  = h_file;
		tbl_we  = 1'b0; tbl_wa  = slot_q; tbl_wd = '0;
		tbl_re  = 1'b0; tbl_ra  = tbl_addr(h_file, h_bi);
		byte_we = 1'b0; byte_wa = {e_blk, off_q[INBLK_W-1:0]}; byte_wd = din_q;
		byte_re = 1'b0; byte_ra = {e_blk, off_q[INBLK_W-1:0]};

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_d       = s_tuser;
					hdl_d      = s_tdata[3:0];
					fid_d      = s_tdata[9:4];
					din_d      = s_tdata[17:10];
					fin_d      = s_tlast;
					res_st_d   = ST_OK;
					res_dout_d = '0;
					res_hout_d = '0;
					res_fout_d = '0;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (op_q)
					OP_CREATE: begin
						if (free_file_cnt_q == '0) begin
							res_st_d = ST_NO_FILE;
						end else begin
							chunk_d = '0;
							state_d = S_FILE_SCAN;
						end
					end
					OP_OPEN: begin
						if (!fid_live) begin
							res_st_d = ST_NOT_FOUND;
						end else if (!hdl_scan.found) begin
							res_st_d = ST_NO_HANDLE;
						end else begin
							handle_valid_d[hdl_scan.idx] = 1'b1;
							handle_file_d[hdl_scan.idx]  = fid_q;
							handle_off_d[hdl_scan.idx]   = '0;
							res_hout_d = hdl_scan.idx;
						end
					end
					OP_CLOSE: begin
						if (!handle_valid_q[hdl_q]) begin
							res_st_d = ST_BAD_HANDLE;
						end else begin
							handle_valid_d[hdl_q] = 1'b0;
						end
					end
					OP_READ, OP_WRITE: begin
						if (!h_ok) begin
							res_st_d = ST_BAD_HANDLE;
						end else if (h_bi >= BI_W'(DIRECT_PER_FILE)) begin
							res_st_d = (op_q == OP_READ) ? ST_EOF : ST_TOO_LARGE;
						end else begin
							// Fetch the length and the table slot together.
							len_re  = 1'b1;
							tbl_re  = 1'b1;
							off_d   = h_off;
							fid_d   = h_file;
							slot_d  = tbl_addr(h_file, h_bi);
							state_d = S_RW_CHK;
						end
					end
					OP_DELETE: begin
						if (!fid_live) begin
							res_st_d = ST_NOT_FOUND;
						end else begin
							idx_d   = '0;
							state_d = S_DEL_RD;
						end
					end
					default: begin
						res_st_d = ST_OK;
					end
				endcase
			end
			S_RW_CHK: begin
				state_d = S_DONE;
				if (op_q == OP_READ) begin
					if (off_q >= len_rd_q || !e_ok) begin
						res_st_d = ST_EOF;
					end else begin
						byte_re = 1'b1;
						state_d = S_BYTE_RD;
					end
				end else if (e_ok) begin
					// Block present: store the byte and advance.
					byte_we             = 1'b1;
					handle_off_d[hdl_q] = off_inc;
					if (off_inc > len_rd_q) begin
						len_we = 1'b1;
						len_wd = off_inc;
					end
				end else if (free_blk_cnt_q == '0) begin
					res_st_d = ST_NO_SPACE;
				end else begin
					chunk_d = '0;
					state_d = S_BLK_SCAN;
				end
			end
			S_BLK_SCAN: begin
				if (blk_scan.found) begin
					block_used_d[new_blk] = 1'b1;
					free_blk_cnt_d        = free_blk_cnt_q - FCNT_W'(1);
					tbl_we                = 1'b1;
					tbl_wd                = ENTRY_W'(new_blk) + ENTRY_W'(1);
					byte_we               = 1'b1;
					byte_wa               = {new_blk, off_q[INBLK_W-1:0]};
					handle_off_d[hdl_q]   = off_inc;
					if (off_inc > len_rd_q) begin
						len_we = 1'b1;
						len_wd = off_inc;
					end
					state_d = S_DONE;
				end else if (chunk_q == '1) begin
					res_st_d = ST_NO_SPACE;
					state_d  = S_DONE;
				end else begin
					chunk_d = chunk_q + CHUNK_W'(1);
				end
			end
			S_BYTE_RD: begin
				res_dout_d          = byte_rd_q;
				handle_off_d[hdl_q] = off_inc;
				state_d             = S_DONE;
			end
			S_FILE_SCAN: begin
				if (file_scan.found) begin
					file_used_d[new_file] = 1'b1;
					free_file_cnt_d       = free_file_cnt_q - FFCNT_W'(1);
					len_we                = 1'b1;
					len_wa                = new_file;
					len_wd                = '0;
					res_fout_d            = new_file;
					fid_d                 = new_file;
					idx_d                 = '0;
					state_d               = S_TBL_CLR;
				end else if (chunk_q[FCHUNK_W-1:0] == '1) begin
					res_st_d = ST_NO_FILE;
					state_d  = S_DONE;
				end else begin
					chunk_d = chunk_q + CHUNK_W'(1);
				end
			end
			S_TBL_CLR: begin
				// Clear one table slot of the new file per cycle.
				tbl_we = 1'b1;
				tbl_wa = tbl_addr(fid_q, idx_q);
				tbl_wd = '0;
				idx_d  = idx_q + BI_W'(1);
				if (idx_q == BI_W'(DIRECT_PER_FILE - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DEL_RD: begin
				tbl_re  = 1'b1;
				tbl_ra  = tbl_addr(fid_q, idx_q);
				state_d = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (e_ok && block_used_q[e_blk]) begin
					block_used_d[e_blk] = 1'b0;
					free_blk_cnt_d      = free_blk_cnt_q + FCNT_W'(1);
				end
				if (idx_q == BI_W'(DIRECT_PER_FILE - 1)) begin
					file_used_d[fid_q] = 1'b0;
					free_file_cnt_d    = free_file_cnt_q + FFCNT_W'(1);
					state_d            = S_DONE;
				end else begin
					idx_d   = idx_q + BI_W'(1);
					state_d = S_DEL_RD;
				end
			end
			S_DONE: begin
				// Hand the result to the output register once it is free.
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_user_d   = res_st_q;
					m_last_d   = fin_q;
					m_data_d   = {7'b0, free_file_cnt_q, free_blk_cnt_q, res_fout_q,
						res_hout_q, res_dout_q};
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			block_used_q    <= '0;
			file_used_q     <= '0;
			handle_valid_q  <= '0;
			free_blk_cnt_q  <= FCNT_W'(DATA_BLOCK_COUNT);
			free_file_cnt_q <= FFCNT_W'(FILE_COUNT - 1);
			m_tvalid_q      <= 1'b0;
		end else begin
			state_q         <= state_d;
			block_used_q    <= block_used_d;
			file_used_q     <= file_used_d;
			handle_valid_q  <= handle_valid_d;
			free_blk_cnt_q  <= free_blk_cnt_d;
			free_file_cnt_q <= free_file_cnt_d;
			m_tvalid_q      <= m_tvalid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		handle_file_q <= handle_file_d;
		handle_off_q  <= handle_off_d;
		op_q          <= op_d;
		hdl_q         <= hdl_d;
		fid_q         <= fid_d;
		din_q         <= din_d;
		fin_q         <= fin_d;
		off_q         <= off_d;
		slot_q        <= slot_d;
		chunk_q       <= chunk_d;
		idx_q         <= idx_d;
		res_st_q      <= res_st_d;
		res_dout_q    <= res_dout_d;
		res_hout_q    <= res_hout_d;
		res_fout_q    <= res_fout_d;
		m_data_q      <= m_data_d;
		m_user_q      <= m_user_d;
		m_last_q      <= m_last_d;
	end

	// File length memory.
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		if (len_re) begin
			len_rd_q <= len_mem[len_ra];
		end
	end

	// Block table memory.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[tbl_ra];
		end
	end

	// Data byte memory.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_wa] <= byte_wd;
		end
		if (byte_re) begin
			byte_rd_q <= byte_mem[byte_ra];
		end
	end

endmodule

`default_nettype wire

/* sim/inode_block_file_store_core_checker.sv */
// ----------------------------------------------------------------------------
// inode_block_file_store_core_checker
// Watches both stream channels, keeps a shadow copy of the file store and
// compares every result transfer with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module inode_block_file_store_core_checker
	import ibfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic [S_USER_W-1:0]   s_tuser,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_DATA_W-1:0]   m_tdata,
	input  wire logic [M_USER_W-1:0]   m_tuser,
	input  wire logic                  m_tlast,
	output int                         fail_count,
	output int                         pending_count
);

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_out;
		logic [3:0] handle_out;
		logic [5:0] file_id_out;
		logic [8:0] spare_blocks;
		logic [5:0] free_files;
		logic       final_out;
	} fs_result_t;

	// Shadow file store.
	bit        blk_used [DATA_BLOCK_COUNT];
	bit        fil_used [FILE_COUNT];
	int        fil_len  [FILE_COUNT];
	int        blk_map  [FILE_COUNT*DIRECT_PER_FILE];
	bit        hdl_open [HANDLE_COUNT];
	int        hdl_fil  [HANDLE_COUNT];
	int        hdl_off  [HANDLE_COUNT];
	logic [7:0] bytes   [DATA_BLOCK_COUNT*BLOCK_BYTES];
	int        nfree_blk;
	int        nfree_fil;
	fs_result_t result_queue[$];

	initial begin
		for (int i = 0; i < DATA_BLOCK_COUNT; i++) blk_used[i] = 0;
		for (int i = 0; i < FILE_COUNT; i++) begin
			fil_used[i] = 0;
			fil_len[i] = 0;
		end
		for (int i = 0; i < FILE_COUNT*DIRECT_PER_FILE; i++) blk_map[i] = 0;
		for (int i = 0; i < HANDLE_COUNT; i++) begin
			hdl_open[i] = 0;
			hdl_fil[i] = 0;
			hdl_off[i] = 0;
		end
		nfree_blk = DATA_BLOCK_COUNT;
		nfree_fil = FILE_COUNT - 1;
	end

	assign pending_count = result_queue.size();

	function automatic bit handle_live(int h);
		return hdl_open[h] && fil_used[hdl_fil[h]];
	endfunction

	// Applies one operation to the shadow store and returns its result.
	function automatic fs_result_t apply_fs_op(logic [2:0] op, int h, int fid,
			logic [7:0] din, logic fin);
		fs_result_t r;
		int f, off, bi, e;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_CREATE: begin
				r.status = ST_NO_FILE;
				for (int i = 1; i < FILE_COUNT; i++) begin
					if (!fil_used[i]) begin
						fil_used[i] = 1;
						nfree_fil--;
						fil_len[i] = 0;
						for (int k = 0; k < DIRECT_PER_FILE; k++)
							blk_map[i*DIRECT_PER_FILE+k] = 0;
						r.status = ST_OK;
						r.file_id_out = 6'(i);
						break;
					end
				end
			end
			OP_OPEN: begin
				if (fid == 0 || !fil_used[fid]) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status = ST_NO_HANDLE;
					for (int i = 0; i < HANDLE_COUNT; i++) begin
						if (!hdl_open[i]) begin
							hdl_open[i] = 1;
							hdl_fil[i] = fid;
							hdl_off[i] = 0;
							r.status = ST_OK;
							r.handle_out = 4'(i);
							break;
						end
					end
				end
			end
			OP_CLOSE: begin
				if (!hdl_open[h]) r.status = ST_BAD_HANDLE;
				else hdl_open[h] = 0;
			end
			OP_READ: begin
				if (!handle_live(h)) begin
					r.status = ST_BAD_HANDLE;
				end else begin
					f = hdl_fil[h];
					off = hdl_off[h];
					bi = off / BLOCK_BYTES;
					e = (bi < DIRECT_PER_FILE) ? blk_map[f*DIRECT_PER_FILE+bi] : 0;
					if (off >= fil_len[f] || e == 0) begin
						r.status = ST_EOF;
					end else begin
						r.data_out = bytes[(e-1)*BLOCK_BYTES + off % BLOCK_BYTES];
						hdl_off[h] = off + 1;
					end
				end
			end
			OP_WRITE: begin
				if (!handle_live(h)) begin
					r.status = ST_BAD_HANDLE;
				end else begin
					f = hdl_fil[h];
					off = hdl_off[h];
					bi = off / BLOCK_BYTES;
					if (bi >= DIRECT_PER_FILE) begin
						r.status = ST_TOO_LARGE;
					end else begin
						e = blk_map[f*DIRECT_PER_FILE+bi];
						if (e == 0) begin
							for (int i = 0; i < DATA_BLOCK_COUNT; i++) begin
								if (!blk_used[i]) begin
									blk_used[i] = 1;
									nfree_blk--;
									e = i + 1;
									blk_map[f*DIRECT_PER_FILE+bi] = e;
									break;
								end
							end
						end
						if (e == 0) begin
							r.status = ST_NO_SPACE;
						end else begin
							bytes[(e-1)*BLOCK_BYTES + off % BLOCK_BYTES] = din;
							hdl_off[h] = off + 1;
							if (off + 1 > fil_len[f]) fil_len[f] = off + 1;
						end
					end
				end
			end
			OP_DELETE: begin
				if (fid == 0 || !fil_used[fid]) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = 0; i < DIRECT_PER_FILE; i++) begin
						e = blk_map[fid*DIRECT_PER_FILE+i];
						if (e != 0 && blk_used[e-1]) begin
							blk_used[e-1] = 0;
							nfree_blk++;
						end
					end
					fil_used[fid] = 0;
					nfree_fil++;
				end
			end
			default: ;
		endcase
		r.spare_blocks = 9'(nfree_blk);
		r.free_files = 6'(nfree_fil);
		r.final_out = fin;
		return r;
	endfunction

	// Predict on each input transfer and compare on each output transfer.
	always @(posedge clk) begin
		fs_result_t got, want;
		if (arst_n && s_tvalid && s_tready)
			result_queue.push_back(apply_fs_op(s_tuser, s_tdata[3:0], s_tdata[9:4],
				s_tdata[17:10], s_tlast));
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.data_out = m_tdata[7:0];
			got.handle_out = m_tdata[11:8];
			got.file_id_out = m_tdata[17:12];
			got.spare_blocks = m_tdata[26:18];
			got.free_files = m_tdata[32:27];
			got.final_out = m_tlast;
			if (result_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result transfer: %p", got);
			end else begin
				want = result_queue.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sim/inode_block_file_store_core_test.sv */
// ----------------------------------------------------------------------------
// inode_block_file_store_core_test
// Drives file operations into the store core under varying stalls and gives
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module inode_block_file_store_core_test;
	import ibfs_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic                m_tlast;
	int                  fail_count;
	int                  pending_count;
	int                  send_idle_pct = 30;
	int                  recv_idle_pct = 60;
	bit                  recv_hold = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	inode_block_file_store_core DUT (.*);

	inode_block_file_store_core_checker checker_inst (.*);

	// Receiver readiness, random unless held off.
	always @(posedge clk) begin
		m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Sends one operation and waits for its transfer. Valid stays high
	// afterwards so that the next operation can follow without a gap.
	task automatic send_op(int op, int h, int fid, int din, int fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= 3'(op);
		s_tdata <= {6'd0, 8'(din), 6'(fid), 4'(h)};
		s_tlast <= 1'(fin);
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every expected result has come.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Mostly well-formed traffic: writes and reads on low files and handles.
	task automatic random_op();
		int r;
		logic [7:0] d;
		r = $urandom_range(99);
		d = 8'($urandom);
		if (r < 6) send_op(OP_CREATE, $urandom, $urandom, d, $urandom);
		else if (r < 14) send_op(OP_OPEN, $urandom, $urandom_range(8), d, $urandom);
		else if (r < 19) send_op(OP_CLOSE, $urandom_range(7), $urandom, d, $urandom);
		else if (r < 50) send_op(OP_WRITE, $urandom_range(7), $urandom, d, $urandom);
		else if (r < 85) send_op(OP_READ, $urandom_range(7), $urandom, d, $urandom);
		else if (r < 89) send_op(OP_DELETE, $urandom, $urandom_range(8), d, $urandom);
		else send_op($urandom_range(7), $urandom, $urandom, d, $urandom);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: error codes on an empty store and field extremes, then one file is created, opened, written and read.
		send_op(OP_OPEN, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_OPEN, 4'd0, 6'd63, 8'hff, 1'b1);
		send_op(OP_CLOSE, 4'd15, 6'd0, 8'h00, 1'b0);
		send_op(OP_READ, 4'd0, 6'd0, 8'h00, 1'b1);
		send_op(OP_WRITE, 4'd15, 6'd63, 8'hff, 1'b0);
		send_op(OP_DELETE, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_DELETE, 4'd0, 6'd63, 8'h00, 1'b1);
		send_op(3'd6, 4'd15, 6'd63, 8'hff, 1'b1);
		send_op(3'd7, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_CREATE, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_OPEN, 4'd0, 6'd1, 8'h00, 1'b0);
		send_op(OP_READ, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_WRITE, 4'd0, 6'd0, 8'hff, 1'b0);
		send_op(OP_WRITE, 4'd0, 6'd0, 8'h00, 1'b1);
		send_op(OP_OPEN, 4'd0, 6'd1, 8'h00, 1'b0);
		send_op(OP_READ, 4'd1, 6'd0, 8'h00, 1'b0);
		send_op(OP_READ, 4'd1, 6'd0, 8'h00, 1'b0);
		send_op(OP_READ, 4'd1, 6'd0, 8'h00, 1'b0);
		// Delete leaves a stale handle, which closes fine afterwards.
		send_op(OP_DELETE, 4'd0, 6'd1, 8'h00, 1'b0);
		send_op(OP_READ, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_CLOSE, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_CLOSE, 4'd0, 6'd0, 8'h00, 1'b0);
		send_op(OP_CLOSE, 4'd1, 6'd0, 8'h00, 1'b0);

		// Fill every file number and every handle.
		for (int i = 0; i < 64; i++) send_op(OP_CREATE, 0, 0, 0, 0);
		for (int i = 0; i < 17; i++) send_op(OP_OPEN, 0, 1 + i % 3, 0, 0);

		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_op(OP_WRITE, i % 4, 0, $urandom, 0);
		join
		wait_drained();

		// Grow file 1 across a block boundary, then free two files.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < BLOCK_BYTES + 8; i++)
			send_op(OP_WRITE, 0, 0, $urandom, i[0]);
		for (int i = 0; i < 2; i++) send_op(OP_DELETE, 0, 1 + i, 0, 0);
		wait_drained();

		// Random phases with changing idle patterns.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 30 : (p == 1) ? 60 : 0;
			recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 30 : 0;
			for (int i = 0; i < 250; i++) random_op();
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("inode_block_file_store_core verification clean");
		else
			$display("inode_block_file_store_core verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("inode_block_file_store_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
